FILE: src/hough_peak_top_k_finder_core_assert.svh
// ----------------------------------------------------------------------------
// hough peak finder assertion macros
// clocked assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef HOUGH_PEAK_TOP_K_FINDER_CORE_ASSERT_SVH
`define HOUGH_PEAK_TOP_K_FINDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HPK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HPK_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HPK_ASSERT(lbl, clk, rstn, prop, msg)
`define HPK_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: src/hpk_pkg.sv
// ----------------------------------------------------------------------------
// hpk_pkg
// shared types and codes of the hough peak finder
// ----------------------------------------------------------------------------
`default_nettype none
package hpk_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 7;
	localparam int OUT_XY_W   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_FLUSH = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} chain_ctrl_t;

endpackage
`default_nettype wire

FILE: src/hpk_line_buf.sv
// ----------------------------------------------------------------------------
// hpk_line_buf
// row store for the two rows above the incoming one, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module hpk_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 64
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/hpk_window.sv
// ----------------------------------------------------------------------------
// hpk_window
// horizontal 3x3 window over column triples and non-maximum test
// ----------------------------------------------------------------------------
`default_nettype none
module hpk_window #(
	parameter int PB = 32,
	parameter int XW = 10,
	parameter int YW = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 col_valid,
	input  wire logic [XW-1:0]        col_x,
	input  wire logic [YW-1:0]        col_y,
	input  wire logic [2:0][PB-1:0]   col_data,
	input  wire logic [XW-1:0]        wlast,
	input  wire logic [31:0]          min_weight,
	output logic                      busy,
	output logic                      peak_valid,
	output logic      [PB-1:0]        peak_value,
	output logic      [XW-1:0]        peak_x,
	output logic      [YW-1:0]        peak_y
);

	localparam int EW = (PB > 32) ? PB : 32;

	logic                 s2_valid;
	logic [XW-1:0]        s2_x;
	logic [YW-1:0]        s2_y;
	logic [2:0][PB-1:0]   s2_col;
	logic [2:0][PB-1:0]   cola_q, colb_q;

	logic                 pend_q;
	logic [XW-1:0]        pend_x_q;
	logic [YW-1:0]        pend_y_q;
	logic [2:0][PB-1:0]   pend_l_q, pend_m_q;

	logic                 j_valid, j_from_s2, pend_set;
	logic [XW-1:0]        j_x;
	logic [2:0][PB-1:0]   j_l, j_m, j_r;

	logic                 s3_valid;
	logic [XW-1:0]        s3_x;
	logic [YW-1:0]        s3_y;
	logic [2:0][2:0][PB-1:0] s3_win;

	logic [PB-1:0]        ctr;
	logic                 all_ge, any_gt, ge_min;

	// center column judged one column late; the row end column comes from pend
	always_comb begin
		j_from_s2 = 1'b0;
		j_x       = s2_x;
		j_l       = s2_col;
		j_m       = s2_col;
		j_r       = s2_col;
		if (s2_valid && wlast == '0) begin
			j_from_s2 = 1'b1;
		end else if (s2_valid && s2_x != '0) begin
			j_from_s2 = 1'b1;
			j_x       = s2_x - 1'b1;
			j_l       = (s2_x == XW'(1)) ? colb_q : cola_q;
			j_m       = colb_q;
		end
		if (!j_from_s2) begin
			j_x = pend_x_q;
			j_l = pend_l_q;
			j_m = pend_m_q;
			j_r = pend_m_q;
		end
		j_valid  = j_from_s2 || pend_q;
		pend_set = s2_valid && wlast != '0 && s2_x == wlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			pend_q   <= 1'b0;
			s3_valid <= 1'b0;
		end else begin
			s2_valid <= col_valid;
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (!j_from_s2) begin
				pend_q <= 1'b0;
			end
			s3_valid <= j_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (col_valid) begin
			s2_x   <= col_x;
			s2_y   <= col_y;
			s2_col <= col_data;
		end
		if (s2_valid) begin
			cola_q <= colb_q;
			colb_q <= s2_col;
		end
		if (pend_set) begin
			pend_x_q <= s2_x;
			pend_y_q <= s2_y;
			pend_l_q <= colb_q;
			pend_m_q <= s2_col;
		end
		if (j_valid) begin
			s3_x      <= j_x;
			s3_y      <= j_from_s2 ? s2_y : pend_y_q;
			s3_win[0] <= j_l;
			s3_win[1] <= j_m;
			s3_win[2] <= j_r;
		end
	end

	always_comb begin
		ctr    = s3_win[1][1];
		all_ge = 1'b1;
		any_gt = 1'b0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if ($signed(ctr) < $signed(s3_win[c][r])) begin
					all_ge = 1'b0;
				end
				if ($signed(ctr) > $signed(s3_win[c][r])) begin
					any_gt = 1'b1;
				end
			end
		end
		ge_min = $signed(EW'($signed(ctr))) >= $signed(EW'($signed(min_weight)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_valid <= 1'b0;
		end else begin
			peak_valid <= s3_valid && all_ge && any_gt && ge_min;
		end
	end

	always_ff @(posedge clk) begin
		peak_value <= ctr;
		peak_x     <= s3_x;
		peak_y     <= s3_y;
	end

	assign busy = s2_valid || pend_q || s3_valid || peak_valid;

endmodule
`default_nettype wire

FILE: src/hpk_cell.sv
// ----------------------------------------------------------------------------
// hpk_cell
// one slot of the sorted peak chain
// ----------------------------------------------------------------------------
`default_nettype none
module hpk_cell
	import hpk_pkg::*;
#(
	parameter int PB = 32,
	parameter int XW = 10,
	parameter int YW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire chain_ctrl_t   ctrl,
	input  wire logic [PB-1:0] new_value,
	input  wire logic [XW-1:0] new_x,
	input  wire logic [YW-1:0] new_y,
	input  wire logic          prev_keep,
	input  wire logic          prev_valid,
	input  wire logic [PB-1:0] prev_value,
	input  wire logic [XW-1:0] prev_x,
	input  wire logic [YW-1:0] prev_y,
	input  wire logic          next_valid,
	input  wire logic [PB-1:0] next_value,
	input  wire logic [XW-1:0] next_x,
	input  wire logic [YW-1:0] next_y,
	output logic               keep,
	output logic               valid_q,
	output logic      [PB-1:0] value_q,
	output logic      [XW-1:0] x_q,
	output logic      [YW-1:0] y_q
);

	// equal values stay ahead of the newcomer
	assign keep = valid_q && ($signed(value_q) >= $signed(new_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
			x_q     <= next_x;
			y_q     <= next_y;
		end else if (ctrl.insert && !keep) begin
			value_q <= prev_keep ? new_value : prev_value;
			x_q     <= prev_keep ? new_x : prev_x;
			y_q     <= prev_keep ? new_y : prev_y;
		end
	end

endmodule
`default_nettype wire

FILE: src/hough_peak_top_k_finder_core.sv
// ----------------------------------------------------------------------------
// hough_peak_top_k_finder_core
// 3x3 non-maximum peak detection on a hough accumulator with top-k chain
// ----------------------------------------------------------------------------
// pixel items enter on in_valid/in_ready in raster order, one per cycle
// inside a frame. centers are judged one row behind the input through a
// two-row line buffer, a column window and a compare stage; each peak
// inserts into a sorted chain of TOP_K cells, up to CANDIDATE_LIMIT + 1 per frame.
// after the last pixel of a frame in_ready drops: the block replays the
// last row from the line buffer, drains its pipeline, then presents the
// kept peaks on out_valid/out_ready, strongest first, one per cycle while
// out_ready stays high. an empty frame gives one item with peak_found low.
// a stalled receiver holds the current item; in_ready comes back the cycle
// after the last one is taken. reset clears counters and the chain and
// loads the default registers; writing frame_width or frame_height
// restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hough_peak_top_k_finder_core_assert.svh"
module hough_peak_top_k_finder_core
	import hpk_pkg::*;
#(
	parameter int MAX_WIDTH       = 1024,
	parameter int MAX_HEIGHT      = 1024,
	parameter int TOP_K           = 64,
	parameter int CANDIDATE_LIMIT = 10000,
	parameter int PIXEL_BITS      = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [31:0]           pixel_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [31:0]           peak_value,
	output logic      [OUT_XY_W-1:0]   peak_x,
	output logic      [OUT_XY_W-1:0]   peak_y,
	output logic                       peak_found,
	output logic                       last_peak
);

	localparam int PB = PIXEL_BITS;
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW = $clog2(CANDIDATE_LIMIT + 2);
	localparam logic [CW-1:0] CAND_LIM = CW'(CANDIDATE_LIMIT);
	localparam logic [CNT_W-1:0] K_MAX = CNT_W'(TOP_K);
	localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	function automatic int last_of(input logic [10:0] v, input int lim);
		int n;
		n = int'(v);
		if (n == 0) n = 1;
		if (n > lim) n = lim;
		return n - 1;
	endfunction

	state_t          state_q;
	logic [XW-1:0]   col_q, wlast_q;
	logic [YW-1:0]   row_q, hlast_q;
	logic [31:0]     min_weight_q;
	logic [6:0]      max_count_q;
	logic [CNT_W-1:0] fill_q, left_q, lim, cnt;
	logic [CW-1:0]   cand_q;
	logic            restart;

	logic            acc, s0_go, out_acc, empty;
	logic [PB-1:0]   pix;

	logic            s1_valid, s1_flush, s1_fwd;
	logic [XW-1:0]   s1_x;
	logic [YW-1:0]   s1_y;
	logic [PB-1:0]   s1_v;
	logic [2*PB-1:0] s1_fwd_word, rd_data, word, wr_data;
	logic            wr_en;
	logic [PB-1:0]   r1, r2;
	logic [2:0][PB-1:0] col_data;
	logic            col_valid;
	logic [YW-1:0]   col_y;

	logic            win_busy, pk_valid;
	logic [PB-1:0]   pk_value;
	logic [XW-1:0]   pk_x;
	logic [YW-1:0]   pk_y;
	chain_ctrl_t     cctl;

	logic            c_keep  [TOP_K];
	logic            c_valid [TOP_K];
	logic [PB-1:0]   c_value [TOP_K];
	logic [XW-1:0]   c_x     [TOP_K];
	logic [YW-1:0]   c_y     [TOP_K];

	generate
		if (PB <= 32) begin : g_pix_narrow
			assign pix = pixel_value[PB-1:0];
			assign peak_value = empty ? 32'd0 : 32'($signed(c_value[0]));
		end else begin : g_pix_wide
			assign pix = {{(PB-32){1'b0}}, pixel_value};
			assign peak_value = empty ? 32'd0 : c_value[0][31:0];
		end
	endgenerate

	assign in_ready  = (state_q == ST_RUN);
	assign acc       = in_valid && in_ready;
	assign s0_go     = acc || (state_q == ST_FLUSH);
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc   = out_valid && out_ready;
	assign empty     = (left_q == '0);
	assign last_peak = empty || (left_q == CNT_W'(1));
	assign peak_found = !empty;

	logic [XW+OUT_XY_W-1:0] x_ext;
	logic [YW+OUT_XY_W-1:0] y_ext;
	assign x_ext  = {{OUT_XY_W{1'b0}}, c_x[0]};
	assign y_ext  = {{OUT_XY_W{1'b0}}, c_y[0]};
	assign peak_x = empty ? '0 : x_ext[OUT_XY_W-1:0];
	assign peak_y = empty ? '0 : y_ext[OUT_XY_W-1:0];

	always_comb begin
		if (max_count_q == '0) begin
			lim = CNT_W'(1);
		end else if (max_count_q > K_MAX) begin
			lim = K_MAX;
		end else begin
			lim = max_count_q;
		end
		cnt = (fill_q < lim) ? fill_q : lim;
	end

	assign restart = (out_acc && last_peak) ||
		(cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT));

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			col_q        <= '0;
			row_q        <= '0;
			wlast_q      <= XW'(RST_W - 1);
			hlast_q      <= YW'(RST_H - 1);
			min_weight_q <= '0;
			max_count_q  <= 7'd64;
			left_q       <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (acc) begin
						if (col_q == wlast_q) begin
							col_q <= '0;
							if (row_q == hlast_q) begin
								row_q   <= '0;
								state_q <= ST_FLUSH;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (col_q == wlast_q) begin
						col_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!s1_valid && !win_busy) begin
						left_q  <= cnt;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last_peak) begin
							state_q <= ST_RUN;
						end else begin
							left_q <= left_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			if (cfg_write) begin
				case (cfg_index)
					REG_MIN_WEIGHT: min_weight_q <= cfg_data;
					REG_MAX_COUNT: max_count_q <= cfg_data[6:0];
					REG_FRAME_WIDTH: begin
						wlast_q <= XW'(last_of(cfg_data[10:0], MAX_WIDTH));
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_FRAME_HEIGHT: begin
						hlast_q <= YW'(last_of(cfg_data[10:0], MAX_HEIGHT));
						col_q   <= '0;
						row_q   <= '0;
					end
					default: begin
						min_weight_q <= min_weight_q;
					end
				endcase
			end
		end
	end

	// stage 1: line buffer read, same-address forward for one-column frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= s0_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s0_go) begin
			s1_flush    <= (state_q == ST_FLUSH);
			s1_x        <= col_q;
			s1_y        <= row_q;
			s1_v        <= pix;
			s1_fwd      <= wr_en && (s1_x == col_q);
			s1_fwd_word <= wr_data;
		end
	end

	hpk_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW),
		.DW    (2 * PB)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (s0_go),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (s1_x),
		.wr_data (wr_data)
	);

	assign word    = s1_fwd ? s1_fwd_word : rd_data;
	assign r2      = word[2*PB-1:PB];
	assign r1      = word[PB-1:0];
	assign wr_en   = s1_valid && !s1_flush;
	assign wr_data = {r1, s1_v};

	// column triple for center row: top, middle, bottom with edge clamping
	always_comb begin
		col_y       = s1_flush ? hlast_q : (s1_y - 1'b1);
		col_valid   = s1_valid && (s1_flush || s1_y != '0);
		col_data[2] = (col_y == '0) ? r1 : r2;
		col_data[1] = r1;
		col_data[0] = s1_flush ? r1 : s1_v;
	end

	hpk_window #(
		.PB (PB),
		.XW (XW),
		.YW (YW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.col_valid  (col_valid),
		.col_x      (s1_x),
		.col_y      (col_y),
		.col_data   (col_data),
		.wlast      (wlast_q),
		.min_weight (min_weight_q),
		.busy       (win_busy),
		.peak_valid (pk_valid),
		.peak_value (pk_value),
		.peak_x     (pk_x),
		.peak_y     (pk_y)
	);

	assign cctl.insert = pk_valid && (cand_q <= CAND_LIM);
	assign cctl.shift  = out_acc && !last_peak;
	assign cctl.clear  = restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cand_q <= '0;
		end else if (restart) begin
			fill_q <= '0;
			cand_q <= '0;
		end else if (cctl.insert) begin
			cand_q <= cand_q + 1'b1;
			if (fill_q < K_MAX) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	generate
		for (genvar i = 0; i < TOP_K; i++) begin : g_chain
			logic          p_keep, p_valid, n_valid;
			logic [PB-1:0] p_value, n_value;
			logic [XW-1:0] p_x, n_x;
			logic [YW-1:0] p_y, n_y;
			if (i == 0) begin : g_head
				assign p_keep  = 1'b1;
				assign p_valid = 1'b0;
				assign p_value = '0;
				assign p_x     = '0;
				assign p_y     = '0;
			end else begin : g_body
				assign p_keep  = c_keep[i-1];
				assign p_valid = c_valid[i-1];
				assign p_value = c_value[i-1];
				assign p_x     = c_x[i-1];
				assign p_y     = c_y[i-1];
			end
			if (i == TOP_K - 1) begin : g_tail
				assign n_valid = 1'b0;
				assign n_value = '0;
				assign n_x     = '0;
				assign n_y     = '0;
			end else begin : g_link
				assign n_valid = c_valid[i+1];
				assign n_value = c_value[i+1];
				assign n_x     = c_x[i+1];
				assign n_y     = c_y[i+1];
			end
			hpk_cell #(
				.PB (PB),
				.XW (XW),
				.YW (YW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (cctl),
				.new_value  (pk_value),
				.new_x      (pk_x),
				.new_y      (pk_y),
				.prev_keep  (p_keep),
				.prev_valid (p_valid),
				.prev_value (p_value),
				.prev_x     (p_x),
				.prev_y     (p_y),
				.next_valid (n_valid),
				.next_value (n_value),
				.next_x     (n_x),
				.next_y     (n_y),
				.keep       (c_keep[i]),
				.valid_q    (c_valid[i]),
				.value_q    (c_value[i]),
				.x_q        (c_x[i]),
				.y_q        (c_y[i])
			);
		end
	endgenerate

	`HPK_NEVER(a_fill_bound, clk, arst_n, fill_q > K_MAX, "chain fill above depth")
	`HPK_NEVER(a_cand_bound, clk, arst_n, cand_q > CAND_LIM + 1'b1, "candidate count overrun")
	`HPK_ASSERT(a_emit_done, clk, arst_n, out_acc && last_peak |=> in_ready, "frame not released")
	`HPK_NEVER(a_emit_idle, clk, arst_n, out_valid && (s1_valid || win_busy), "emit with work in flight")

endmodule
`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for hough_peak_top_k_finder_core
// streams accumulator frames through the core with random idling on both
// sides, predicts the emitted peaks per frame and checks every result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import hpk_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic [9:0]  x;
		logic [9:0]  y;
		logic        found;
		logic        last;
	} peak_t;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int KEEP = 64;
	localparam int CAND_LIMIT = 10000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] pixel_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] peak_value;
	logic [OUT_XY_W-1:0] peak_x, peak_y;
	logic peak_found, last_peak;

	hough_peak_top_k_finder_core dut (.*);

	logic [31:0] pixel_q[$];
	peak_t peaks_due[$];
	int errors = 0;
	int pixels_taken = 0;
	int peaks_seen = 0;
	int frames_seen = 0;
	logic in_taken = 1'b0;
	bit quiet = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_cycles = 0;

	// predictor state
	logic signed [31:0] line_prev[MAXW];
	logic signed [31:0] line_curr[MAXW];
	logic signed [31:0] line_next[MAXW];
	int unsigned col = 0, row = 0, fill = 0, cands = 0;
	logic signed [31:0] kept_v[KEEP];
	int unsigned kept_x[KEEP], kept_y[KEEP];
	logic signed [31:0] thresh = 0;
	int unsigned count_reg = 64, width_reg = 1024, height_reg = 1024;

	initial forever #2 clk = ~clk;

	function automatic void add_pixel(logic [31:0] v);
		pixel_q.insert(pixel_q.size(), v);
	endfunction

	function automatic void add_peak(peak_t pk);
		peaks_due.insert(peaks_due.size(), pk);
	endfunction

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		return width_reg > MAXW ? MAXW : width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg == 0) return 1;
		return height_reg > MAXH ? MAXH : height_reg;
	endfunction

	function automatic void restart_frame();
		col = 0;
		row = 0;
		fill = 0;
		cands = 0;
	endfunction

	function automatic logic signed [31:0] line_at(int sel, int unsigned i);
		case (sel)
			0: return line_prev[i];
			1: return line_curr[i];
			default: return line_next[i];
		endcase
	endfunction

	function automatic void keep_peak(logic signed [31:0] v, int unsigned x, int unsigned y);
		int unsigned pos, last_i;
		pos = 0;
		while (pos < fill && kept_v[pos] >= v) pos++;
		if (pos >= KEEP) return;
		last_i = (fill < KEEP) ? fill : KEEP - 1;
		for (int unsigned i = last_i; i > pos; i--) begin
			kept_v[i] = kept_v[i-1];
			kept_x[i] = kept_x[i-1];
			kept_y[i] = kept_y[i-1];
		end
		kept_v[pos] = v;
		kept_x[pos] = x;
		kept_y[pos] = y;
		if (fill < KEEP) fill++;
	endfunction

	function automatic void scan_row(int p, int c, int n, int unsigned y, int unsigned w);
		logic signed [31:0] v;
		int unsigned lo, hi;
		bit ok, gt;
		for (int unsigned x = 0; x < w; x++) begin
			if (cands > CAND_LIMIT) return;
			v = line_at(c, x);
			if (v < thresh) continue;
			lo = (x > 0) ? x - 1 : 0;
			hi = (x + 1 < w) ? x + 1 : w - 1;
			ok = 1;
			gt = 0;
			for (int unsigned xx = lo; xx <= hi && ok; xx++) begin
				if (v < line_at(p, xx) || v < line_at(c, xx) || v < line_at(n, xx))
					ok = 0;
				else if (v > line_at(p, xx) || v > line_at(c, xx) || v > line_at(n, xx))
					gt = 1;
			end
			if (ok && gt) begin
				keep_peak(v, x, y);
				cands++;
			end
		end
	endfunction

	function automatic void queue_frame_peaks();
		int unsigned lim, cnt;
		peak_t pk;
		lim = count_reg;
		if (lim == 0) lim = 1;
		if (lim > KEEP) lim = KEEP;
		cnt = fill < lim ? fill : lim;
		if (cnt == 0) begin
			pk = '{value: '0, x: '0, y: '0, found: 1'b0, last: 1'b1};
			add_peak(pk);
		end
		for (int unsigned k = 0; k < cnt; k++) begin
			pk.value = kept_v[k];
			pk.x = kept_x[k][9:0];
			pk.y = kept_y[k][9:0];
			pk.found = 1'b1;
			pk.last = (k + 1 == cnt);
			add_peak(pk);
		end
		restart_frame();
	endfunction

	function automatic void take_pixel(logic signed [31:0] v);
		int unsigned w, h, x, y;
		w = eff_w();
		h = eff_h();
		x = col;
		y = row;
		if (x >= w || y >= h) begin
			restart_frame();
			x = 0;
			y = 0;
		end
		if (y == 0) line_curr[x] = v;
		else line_next[x] = v;
		if (x + 1 < w) begin
			col = x + 1;
			return;
		end
		col = 0;
		if (y == 0) begin
			if (h == 1) begin
				scan_row(1, 1, 1, 0, w);
				queue_frame_peaks();
			end else begin
				row = 1;
			end
			return;
		end
		scan_row(y == 1 ? 1 : 0, 1, 2, y - 1, w);
		if (y + 1 == h) begin
			scan_row(1, 2, 2, y, w);
			queue_frame_peaks();
			return;
		end
		for (int unsigned i = 0; i < w; i++) begin
			line_prev[i] = line_curr[i];
			line_curr[i] = line_next[i];
		end
		row = y + 1;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pixel_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
				pixel_value <= pixel_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cycles <= 400;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || $urandom_range(99) >= 9;
		end
	end

	// monitor
	always @(posedge clk) begin
		peak_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			take_pixel(pixel_value);
			pixels_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			peaks_seen++;
			if (last_peak) frames_seen++;
			if (peaks_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item value %h x %0d y %0d",
					peak_value, peak_x, peak_y);
			end else begin
				want = peaks_due.pop_front();
				if (peak_value !== want.value || peak_x !== want.x || peak_y !== want.y ||
				    peak_found !== want.found || last_peak !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h %0d %0d f%b l%b got %h %0d %0d f%b l%b",
							want.value, want.x, want.y, want.found, want.last,
							peak_value, peak_x, peak_y, peak_found, last_peak);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_MIN_WEIGHT: thresh = data;
			REG_MAX_COUNT: count_reg = data & 32'h7f;
			REG_FRAME_WIDTH: begin
				width_reg = data & 32'h7ff;
				restart_frame();
			end
			default: begin
				height_reg = data & 32'h7ff;
				restart_frame();
			end
		endcase
	endtask

	task automatic wait_drained();
		wait (pixel_q.size() == 0 && !in_valid);
		wait (peaks_due.size() == 0);
		repeat (eff_w() + 30) @(posedge clk);
	endtask

	task automatic set_frame(int unsigned thr, int unsigned cnt, int unsigned w, int unsigned h);
		write_reg(REG_MIN_WEIGHT, thr);
		write_reg(REG_MAX_COUNT, cnt);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// mode 0: plateau-heavy small values, 1: full range, 2: rail values
	task automatic push_frame(int mode);
		int unsigned n;
		n = eff_w() * eff_h();
		for (int unsigned i = 0; i < n; i++)
			case (mode)
				0: add_pixel($urandom_range(4) - 1);
				1: add_pixel($urandom);
				default: add_pixel($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
			endcase
	endtask

	initial begin
		int phase;
		int nframes;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single strongest center against the most negative neighbors
		set_frame(0, 64, 3, 3);
		for (int i = 0; i < 9; i++) add_pixel(i == 4 ? 32'h7fffffff : 32'h80000000);
		wait_drained();
		// zero size acts as one pixel: flat window, empty frame
		set_frame(32'h80000000, 0, 0, 0);
		add_pixel(32'h12345678);
		wait_drained();
		// two rows of rail values, count clamped low
		set_frame(32'h80000000, 0, 4, 2);
		push_frame(2);
		wait_drained();
		set_frame(32'h7fffffff, 127, 3, 2);
		add_pixel(32'h7fffffff);
		for (int i = 0; i < 5; i++) add_pixel(32'hffffffff);
		wait_drained();
		// oversized sizes saturate; the next size write drops the open frame
		set_frame(32'h80000000, 127, 2047, 2047);
		for (int i = 0; i < 60; i++) add_pixel($urandom);
		wait_drained();

		phase = 0;
		while (pixels_taken < 280 || phase < 4) begin
			quiet = (phase == 1);
			case ($urandom_range(3))
				0: write_reg(REG_MIN_WEIGHT, 32'h80000000);
				1: write_reg(REG_MIN_WEIGHT, $urandom);
				default: write_reg(REG_MIN_WEIGHT, $urandom_range(3) - 1);
			endcase
			write_reg(REG_MAX_COUNT, $urandom_range(5) == 0 ? 64 : $urandom_range(8));
			write_reg(REG_FRAME_WIDTH, $urandom_range(1, 8));
			write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 6));
			nframes = $urandom_range(1, 3);
			if (phase == 3) nframes = 3;
			for (int f = 0; f < nframes; f++) push_frame($urandom_range(4) == 0 ? 1 : 0);
			if (phase == 3) hold_req = 1;
			wait_drained();
			phase++;
		end

		$display("covered %0d pixel items, %0d frames, %0d result items", pixels_taken,
			frames_seen, peaks_seen);
		$display("sizes from one pixel to an oversized open frame, counts and thresholds at both ends");
		if (errors == 0 && peaks_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout");
		$display("testbench: errors");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/hpk_pkg.sv
src/hpk_line_buf.sv
src/hpk_window.sv
src/hpk_cell.sv
src/hough_peak_top_k_finder_core.sv
test/testbench.sv
